// File: hdl/dms_pkg.sv
`default_nettype none

package dms_pkg;

  localparam int unsigned POS_W   = 28;
  localparam int unsigned LEN_W   = 29;
  localparam int unsigned SUM_W   = 33;
  localparam int unsigned SER_W   = 32;

  localparam logic [7:0]       MARK_BIG    = 8'h42;
  localparam logic [7:0]       MARK_LITTLE = 8'h6C;
  localparam logic [7:0]       PROTO_VER   = 8'h01;
  localparam logic [LEN_W-1:0] LIMIT_CAP   = 29'h1000_0000;
  localparam logic [LEN_W-1:0] LEN_SAT     = 29'h1FFF_FFFF;
  localparam logic [SUM_W-1:0] HDR_LEN     = 33'd16;

  typedef enum logic [3:0] {
    ST_HDR_OK    = 4'd0,
    ST_BODY      = 4'd1,
    ST_MSG_END   = 4'd2,
    ST_ERR_END   = 4'd3,
    ST_ERR_TYPE  = 4'd4,
    ST_ERR_FLAGS = 4'd5,
    ST_ERR_VER   = 4'd6,
    ST_ERR_SER   = 4'd7,
    ST_ERR_LEN   = 4'd8,
    ST_HALTED    = 4'd9
  } dms_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
  } dms_in_t;

  typedef struct packed {
    dms_status_t       status;
    logic              last_of_message;
    logic [POS_W-1:0]  byte_position;
    logic [LEN_W-1:0]  message_length;
    logic [SER_W-1:0]  message_serial;
    logic              is_big_endian;
  } dms_out_t;

  typedef struct packed {
    logic [LEN_W-1:0] max_message_length;
  } dms_cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
  } dms_req_t;

endpackage

`default_nettype wire

// File: hdl/dms_stream_if.sv
`default_nettype none

interface dms_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/dms_in_stage.sv
`default_nettype none

module dms_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire dms_pkg::dms_in_t in_data,
  output logic                 in_ready,
  input  wire logic            take,
  output dms_pkg::dms_req_t    req
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       valid_nxt;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data.data_byte;
    end
  end

  assign req.valid     = valid_r;
  assign req.data_byte = byte_r;

endmodule

`default_nettype wire

// File: hdl/dms_core.sv
`default_nettype none

module dms_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dms_pkg::dms_req_t req,
  output logic                   take,
  input  wire logic              cfg_we,
  input  wire dms_pkg::dms_cfg_t cfg_data,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output dms_pkg::dms_out_t      out_data
);

  logic [dms_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [dms_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [dms_pkg::SER_W-1:0] serial_r, serial_nxt;
  logic                      big_r, big_nxt;
  logic                      halted_r, halted_nxt;
  logic [dms_pkg::LEN_W-1:0] limit_r;
  logic                      out_valid_r;
  dms_pkg::dms_out_t         out_r, out_nxt;

  logic [dms_pkg::POS_W-1:0] p;
  logic [7:0]                b;
  logic                      start;
  logic                      hdr;
  logic [1:0]                lane;
  logic [dms_pkg::SER_W-1:0] lane_val;
  logic [dms_pkg::LEN_W-1:0] len_base;
  logic [dms_pkg::SUM_W-1:0] len_sum;
  logic [2:0]                pad;
  logic                      pad_en;
  logic [dms_pkg::LEN_W-1:0] limit_eff;
  logic                      err;
  dms_pkg::dms_status_t      err_code;
  logic [dms_pkg::LEN_W-1:0] len_sat;
  logic [dms_pkg::LEN_W-1:0] pos_inc;

  assign take      = req.valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    p          = pos_r;
    b          = req.data_byte;
    start      = (p == '0);
    hdr        = (p[dms_pkg::POS_W-1:4] == '0);
    big_nxt    = start ? 1'b0 : big_r;
    len_base   = start ? '0 : len_r;
    serial_nxt = start ? '0 : serial_r;
    lane       = big_nxt ? (2'd3 - p[1:0]) : p[1:0];
    lane_val   = {24'b0, b} << {lane, 3'b000};
    len_sum    = {4'b0, len_base};
    pad        = 3'(4'd8 - {1'b0, b[2:0]});
    pad_en     = 1'b0;
    limit_eff  = (limit_r > dms_pkg::LIMIT_CAP) ? dms_pkg::LIMIT_CAP : limit_r;
    err        = 1'b0;
    err_code   = dms_pkg::ST_HALTED;
    halted_nxt = halted_r;
    pos_nxt    = pos_r;
    pos_inc    = {1'b0, p} + 29'd1;
    out_nxt    = out_r;

    if (hdr) begin
      case (p[3:0]) inside
        4'd0: begin
          if (b == dms_pkg::MARK_BIG) begin
            big_nxt = 1'b1;
          end else if (b != dms_pkg::MARK_LITTLE) begin
            err      = 1'b1;
            err_code = dms_pkg::ST_ERR_END;
          end
        end
        4'd1: begin
          if (!(b inside {[8'd1:8'd4]})) begin
            err      = 1'b1;
            err_code = dms_pkg::ST_ERR_TYPE;
          end
        end
        4'd2: begin
          if (b[7:2] != '0) begin
            err      = 1'b1;
            err_code = dms_pkg::ST_ERR_FLAGS;
          end
        end
        4'd3: begin
          if (b != dms_pkg::PROTO_VER) begin
            err      = 1'b1;
            err_code = dms_pkg::ST_ERR_VER;
          end
        end
        [4'd4:4'd7]: begin
          len_sum = ((p[3:0] == 4'd4) ? dms_pkg::HDR_LEN : {4'b0, len_base})
                    + {1'b0, lane_val};
        end
        [4'd8:4'd11]: begin
          serial_nxt = serial_nxt | lane_val;
          if (p[3:0] == 4'd11 && serial_nxt == '0) begin
            err      = 1'b1;
            err_code = dms_pkg::ST_ERR_SER;
          end
        end
        default: begin
          pad_en  = (p[3:0] == 4'd12 && !big_nxt) || (p[3:0] == 4'd15 && big_nxt);
          len_sum = {4'b0, len_base} + {1'b0, lane_val}
                    + (pad_en ? {30'b0, pad} : '0);
        end
      endcase
      if (len_sum > {4'b0, limit_eff}) begin
        err      = 1'b1;
        err_code = dms_pkg::ST_ERR_LEN;
      end
    end

    len_sat = (len_sum > {4'b0, dms_pkg::LEN_SAT}) ? dms_pkg::LEN_SAT
                                                  : len_sum[dms_pkg::LEN_W-1:0];
    len_nxt = len_sat;

    out_nxt.byte_position   = p;
    out_nxt.message_length  = len_sat;
    out_nxt.message_serial  = serial_nxt;
    out_nxt.is_big_endian   = big_nxt;
    out_nxt.last_of_message = 1'b0;

    if (halted_r) begin
      big_nxt                = big_r;
      len_nxt                = len_r;
      serial_nxt             = serial_r;
      out_nxt.status         = dms_pkg::ST_HALTED;
      out_nxt.message_length = len_r;
      out_nxt.message_serial = serial_r;
      out_nxt.is_big_endian  = big_r;
    end else if (err) begin
      halted_nxt     = 1'b1;
      out_nxt.status = err_code;
    end else if (p >= 28'd15 && {4'b0, pos_inc} == len_sum) begin
      pos_nxt                 = '0;
      out_nxt.status          = dms_pkg::ST_MSG_END;
      out_nxt.last_of_message = 1'b1;
    end else begin
      pos_nxt        = pos_inc[dms_pkg::POS_W-1:0];
      out_nxt.status = hdr ? dms_pkg::ST_HDR_OK : dms_pkg::ST_BODY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      len_r       <= '0;
      serial_r    <= '0;
      big_r       <= 1'b0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= dms_pkg::LIMIT_CAP;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_data.max_message_length;
      end
      if (take) begin
        pos_r    <= pos_nxt;
        len_r    <= len_nxt;
        serial_r <= serial_nxt;
        big_r    <= big_nxt;
        halted_r <= halted_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/dbus_message_splitter.sv
// D-Bus message splitter: takes one stream byte per request on in_ch and
// returns one result per byte on out_ch, in order, with the fixed-header
// check status, the byte's offset in its message, the running total length,
// serial and byte order; the last byte of each message is flagged. Any
// header error halts the block until reset, after which every byte reports
// halted. Throughput is one byte per clock while out_ch is ready: the input
// register and the result register sit around a single pass of header logic
// whose longest path is the 33-bit length add and limit compare. The size
// limit is written over cfg_ch, which is always ready; write it only while
// no byte is in flight.
`default_nettype none

module dbus_message_splitter (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dms_stream_if.sink   in_ch,
  dms_stream_if.sink   cfg_ch,
  dms_stream_if.source out_ch
);

  dms_pkg::dms_req_t req;
  logic              take;
  logic              in_ready;
  logic              out_valid;
  dms_pkg::dms_out_t out_data;
  dms_pkg::dms_in_t  in_data;
  dms_pkg::dms_cfg_t cfg_data;

  assign in_data.data_byte           = in_ch.data.data_byte;
  assign cfg_data.max_message_length = cfg_ch.data.max_message_length;
  assign in_ch.ready                 = in_ready;
  assign cfg_ch.ready                = 1'b1;
  assign out_ch.valid                = out_valid;
  assign out_ch.data                 = out_data;

  dms_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .take     (take),
    .req      (req)
  );

  dms_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .take      (take),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_of_message |-> out_data.status == dms_pkg::ST_MSG_END)
    else $error("last byte without message end status");

  a_end_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == dms_pkg::ST_MSG_END |->
      out_data.byte_position >= 28'd15 &&
      out_data.message_length == {1'b0, out_data.byte_position} + 29'd1)
    else $error("message end does not match length");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid)
    else $error("request taken but no result");

endmodule

`default_nettype wire

// File: dv/dms_frame_checker.sv
`timescale 1ns / 100ps

module dms_frame_checker
  import dms_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  dms_in_t  in_data,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  dms_cfg_t cfg_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  dms_out_t out_data,
  output int       fail_count,
  output int       pending,
  output int       results_seen,
  output int       messages_seen
);

  logic [28:0] msg_pos;
  logic [33:0] len_sum;
  logic [31:0] serial_sum;
  logic        big_order;
  logic        stuck;
  logic [28:0] size_limit;

  dms_out_t byte_reports_q [$];
  dms_out_t want;

  task automatic advance_frame(input logic [7:0] b, output dms_out_t r);
    dms_status_t st;
    logic [28:0] p;
    logic [28:0] lim;
    logic [1:0]  lane;
    int unsigned sh;
    bit          fault;
    logic        last;
    st    = ST_HDR_OK;
    fault = 1'b0;
    last  = 1'b0;
    p     = msg_pos;
    lane  = p[1:0];
    if (stuck) begin
      st = ST_HALTED;
    end else begin
      if (p == 0) begin
        serial_sum = '0;
        len_sum    = '0;
        big_order  = 1'b0;
      end
      sh = big_order ? 8 * (3 - int'(lane)) : 8 * int'(lane);
      if (p == 0) begin
        if (b == MARK_BIG) begin
          big_order = 1'b1;
        end else if (b != MARK_LITTLE) begin
          st    = ST_ERR_END;
          fault = 1'b1;
        end
      end else if (p == 1) begin
        if (b == 0 || b > 4) begin
          st    = ST_ERR_TYPE;
          fault = 1'b1;
        end
      end else if (p == 2) begin
        if (b[7:2] != 0) begin
          st    = ST_ERR_FLAGS;
          fault = 1'b1;
        end
      end else if (p == 3) begin
        if (b != PROTO_VER) begin
          st    = ST_ERR_VER;
          fault = 1'b1;
        end
      end else if (p <= 7) begin
        if (p == 4) len_sum = 34'd16;
        len_sum = len_sum + (34'(b) << sh);
      end else if (p <= 11) begin
        serial_sum = serial_sum + (32'(b) << sh);
        if (p == 11 && serial_sum == 0) begin
          st    = ST_ERR_SER;
          fault = 1'b1;
        end
      end else if (p <= 15) begin
        len_sum = len_sum + (34'(b) << sh);
        // header-field array is padded to a multiple of 8 bytes; pad taken from its low byte
        if ((p == 12 && !big_order) || (p == 15 && big_order))
          len_sum = len_sum + 34'((4'd8 - {1'b0, b[2:0]}) & 4'd7);
      end
      if (p < 16) begin
        lim = (size_limit > LIMIT_CAP) ? LIMIT_CAP : size_limit;
        if (len_sum > 34'(lim)) begin
          st    = ST_ERR_LEN;
          fault = 1'b1;
        end
      end
      if (fault) begin
        stuck = 1'b1;
      end else if (p >= 15 && 34'(p) + 34'd1 == len_sum) begin
        msg_pos = '0;
        st      = ST_MSG_END;
        last    = 1'b1;
      end else begin
        msg_pos = p + 29'd1;
        st      = (p < 16) ? ST_HDR_OK : ST_BODY;
      end
    end
    r.status          = st;
    r.last_of_message = last;
    r.byte_position   = p[27:0];
    r.message_length  = (len_sum > 34'(LEN_SAT)) ? LEN_SAT : len_sum[28:0];
    r.message_serial  = serial_sum;
    r.is_big_endian   = big_order;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      msg_pos       = '0;
      len_sum       = '0;
      serial_sum    = '0;
      big_order     = 1'b0;
      stuck         = 1'b0;
      size_limit    = LIMIT_CAP;
      fail_count    = 0;
      results_seen  = 0;
      messages_seen = 0;
      byte_reports_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (byte_reports_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result, status %0d pos %0d", $time,
                     out_data.status, out_data.byte_position);
        end else begin
          want = byte_reports_q.pop_front();
          results_seen++;
          if (want.last_of_message) messages_seen++;
          if (out_data.status !== want.status ||
              out_data.last_of_message !== want.last_of_message ||
              out_data.byte_position !== want.byte_position ||
              out_data.message_length !== want.message_length ||
              out_data.message_serial !== want.message_serial ||
              out_data.is_big_endian !== want.is_big_endian) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch exp st=%0d last=%0b pos=%0d len=%0d ser=%h big=%0b",
                       $time, want.status, want.last_of_message, want.byte_position,
                       want.message_length, want.message_serial, want.is_big_endian);
              $display("%0t:          got st=%0d last=%0b pos=%0d len=%0d ser=%h big=%0b",
                       $time, out_data.status, out_data.last_of_message,
                       out_data.byte_position, out_data.message_length,
                       out_data.message_serial, out_data.is_big_endian);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) size_limit = cfg_data.max_message_length;
      if (in_valid && in_ready) begin
        advance_frame(in_data.data_byte, want);
        byte_reports_q.push_back(want);
      end
    end
    pending = byte_reports_q.size();
  end

endmodule

// File: dv/tb_dbus_message_splitter.sv
`timescale 1ns / 100ps

module tb_dbus_message_splitter;
  import dms_pkg::*;

  typedef enum int {
    FLT_MARK,
    FLT_TYPE,
    FLT_FLAGS,
    FLT_VERSION,
    FLT_SERIAL,
    FLT_SIZE,
    FLT_LIMIT
  } hdr_fault_t;

  localparam int unsigned TIMEOUT_NS = 2_000_000;
  localparam int unsigned PHASE_BYTES = 250;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  bit          calm = 1'b0;
  int          fail_count;
  int          pending;
  int          results_seen;
  int          messages_seen;
  int unsigned bytes_sent = 0;

  dms_stream_if #(.T(dms_in_t))  in_ch ();
  dms_stream_if #(.T(dms_cfg_t)) cfg_ch ();
  dms_stream_if #(.T(dms_out_t)) out_ch ();

  dbus_message_splitter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  dms_frame_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_data       (in_ch.data),
    .cfg_valid     (cfg_ch.valid),
    .cfg_ready     (cfg_ch.ready),
    .cfg_data      (cfg_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_data      (out_ch.data),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .messages_seen (messages_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= 27);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= dms_in_t'(b);
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_limit(input logic [28:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= dms_cfg_t'(v);
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_message(input bit big, input logic [7:0] mtype, input logic [7:0] flags,
                              input logic [31:0] serial, input int unsigned arr_len,
                              input logic [31:0] body_len, input bit header_only,
                              input int bad_idx, input logic [7:0] bad_val,
                              input int pause_at, input logic [28:0] pause_limit);
    logic [7:0]  hdr [16];
    logic [31:0] words [3];
    int unsigned pad;
    int unsigned total;
    pad      = (8 - (arr_len % 8)) % 8;
    words[0] = body_len;
    words[1] = serial;
    words[2] = arr_len;
    hdr[0]   = big ? MARK_BIG : MARK_LITTLE;
    hdr[1]   = mtype;
    hdr[2]   = flags;
    hdr[3]   = PROTO_VER;
    for (int w = 0; w < 3; w++)
      for (int i = 0; i < 4; i++)
        hdr[4 + 4 * w + i] = big ? words[w][8 * (3 - i) +: 8] : words[w][8 * i +: 8];
    if (bad_idx >= 0) hdr[bad_idx] = bad_val;
    total = header_only ? 16 : 16 + body_len + arr_len + pad;
    for (int i = 0; i < int'(total); i++) begin
      if (i == pause_at) begin
        settle();
        write_limit(pause_limit);
      end
      send_byte(i < 16 ? hdr[i] : 8'($urandom));
    end
  endtask

  initial begin
    logic [28:0] lim;
    int unsigned eff;
    int unsigned room;
    int unsigned arr;
    int unsigned pad;
    int unsigned span;
    int unsigned cap;
    int unsigned body;
    int unsigned phase_end;
    logic [31:0] serial;
    logic [7:0]  bad_val;
    int          bad_idx;
    hdr_fault_t  fault;

    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // shortest messages, both byte orders, extreme header values
    send_message(1'b0, 8'd1, 8'd0, 32'd1, 0, 32'd0, 1'b0, -1, 8'd0, -1, 29'd0);
    send_message(1'b1, 8'd4, 8'd3, 32'hFFFF_FFFF, 0, 32'd0, 1'b0, -1, 8'd0, -1, 29'd0);
    lim = LIMIT_CAP;

    for (int ph = 0; ph < 6; ph++) begin
      // limit lowered mid-body must not touch a message whose header is done
      if (ph == 4)
        send_message($urandom_range(1), 8'($urandom_range(4, 1)), 8'($urandom_range(3)),
                     32'($urandom_range(32'hFFFF_FFFF, 1)), 0, 32'd40, 1'b0, -1, 8'd0,
                     24, 29'd16);
      case (ph)
        0: lim = LIMIT_CAP;
        1: lim = 29'd16;
        2: lim = 29'h1FFF_FFFF;
        3: lim = 29'($urandom_range(300, 100));
        4: lim = 29'($urandom_range(2000, 17));
        default: lim = 29'($urandom_range(64, 16));
      endcase
      settle();
      write_limit(lim);
      calm      = (ph == 2);
      eff       = (lim > LIMIT_CAP) ? LIMIT_CAP : lim;
      room      = eff - 16;
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        arr = $urandom_range(20);
        pad = (8 - (arr % 8)) % 8;
        if (arr + pad > room) begin
          arr = 0;
          pad = 0;
        end
        span = room - arr - pad;
        cap  = ($urandom_range(29) == 0) ? 700 : 40;
        body = $urandom_range(span < cap ? span : cap);
        if ($urandom_range(7) == 0 && span <= cap) body = span;
        case ($urandom_range(7))
          0: serial = 32'd1;
          1: serial = 32'hFFFF_FFFF;
          2: serial = 32'd1 << $urandom_range(31);
          default: serial = $urandom;
        endcase
        if (serial == 0) serial = 32'd1;
        send_message($urandom_range(1), 8'($urandom_range(4, 1)), 8'($urandom_range(3)),
                     serial, arr, body, 1'b0, -1, 8'd0, -1, 29'd0);
        if ($urandom_range(19) == 0) settle();
      end
    end
    calm = 1'b0;

    // one header fault halts the block for the rest of the run
    settle();
    fault   = hdr_fault_t'($urandom_range(FLT_LIMIT));
    serial  = 32'($urandom_range(32'hFFFF_FFFF, 1));
    body    = 0;
    bad_idx = -1;
    bad_val = 8'd0;
    case (fault)
      FLT_MARK: begin
        bad_idx = 0;
        do bad_val = 8'($urandom); while (bad_val == MARK_BIG || bad_val == MARK_LITTLE);
      end
      FLT_TYPE: begin
        bad_idx = 1;
        bad_val = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 5));
      end
      FLT_FLAGS: begin
        bad_idx = 2;
        bad_val = 8'($urandom_range(255, 4));
      end
      FLT_VERSION: begin
        bad_idx = 3;
        do bad_val = 8'($urandom); while (bad_val == PROTO_VER);
      end
      FLT_SERIAL: serial = 32'd0;
      FLT_SIZE:   body = $urandom_range(32'hFFFF_FFFF, 32'h1000_0000);
      default:    write_limit(29'($urandom_range(15)));
    endcase
    send_message($urandom_range(1), 8'($urandom_range(4, 1)), 8'($urandom_range(3)),
                 serial, 0, body, 1'b1, bad_idx, bad_val, -1, 29'd0);
    repeat (20) send_byte(8'($urandom));

    settle();
    repeat (10) @(negedge clk);
    $display("Streamed %0d bytes: %0d results checked, %0d complete messages.",
             bytes_sent, results_seen, messages_seen);
    $display("Limits from 16 to above the cap, a mid-body limit change, closing fault %s.",
             fault.name());
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/dms_pkg.sv
hdl/dms_stream_if.sv
hdl/dms_in_stage.sv
hdl/dms_core.sv
hdl/dbus_message_splitter.sv
dv/dms_frame_checker.sv
dv/tb_dbus_message_splitter.sv
